// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the momentum weight update block.
// Each macro expects i_clk and the active-low reset i_rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define MWU_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define MWU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mwu_pkg.sv =====
// Shared types, constants and helper functions of the momentum weight update block.
// Used by mwu_dp and momentum_weight_update; depends on nothing else.
`default_nettype none

package mwu_pkg;

    localparam int ROWS      = 16;
    localparam int COLS      = 16;
    localparam int FRAC_BITS = 16;

    localparam int WORD_W  = 32;
    localparam int GAIN_W  = 16;
    localparam int FIELD_W = 4;
    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W   = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int ADDR_W  = (ROWS * COLS > 1) ? $clog2(ROWS * COLS) : 1;

    // Gradient magnitude is (|delta*act| * eta) >> (16 + FRAC_BITS), an 80-bit product.
    localparam int PROD_W   = 2 * WORD_W;
    localparam int PART_W   = WORD_W + GAIN_W;
    localparam int FULL_W   = PROD_W + GAIN_W;
    localparam int GRAD_SH  = GAIN_W + FRAC_BITS;
    localparam int GMAG_W   = FULL_W - GRAD_SH;
    localparam int SUM_W    = GMAG_W + 2;

    localparam logic [GAIN_W-1:0] ETA_RESET = 16'd3277;
    localparam logic [GAIN_W-1:0] MU_RESET  = 16'd1966;
    localparam logic [WORD_W-1:0] WORD_MAX  = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] WORD_MIN  = 32'h8000_0000;
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

    localparam int CFG_IDX_W = 1;

    typedef enum logic [1:0] {
        OP_LOAD_WEIGHT = 2'd0,
        OP_LOAD_ACT    = 2'd1,
        OP_APPLY_DELTA = 2'd2,
        OP_READ_WEIGHT = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEARNING_RATE = 1'b0,
        CFG_MOMENTUM_GAIN = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic ld_delta;
        logic latch;
        logic prod;
        logic lo;
        logic hi;
        logic mom;
        logic sum;
        logic clip;
        logic wadd;
    } t_dp_ctrl;

    typedef struct packed {
        logic              sat;
        logic [WORD_W-1:0] val;
    } t_clip;

    function automatic logic [WORD_W-1:0] mag32(input logic [WORD_W-1:0] x);
        return x[WORD_W-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic t_clip clip_word(input logic signed [SUM_W-1:0] x);
        t_clip c;
        c.sat = !((&x[SUM_W-1:WORD_W-1]) || !(|x[SUM_W-1:WORD_W-1]));
        if (c.sat) begin
            c.val = x[SUM_W-1] ? WORD_MIN : WORD_MAX;
        end else begin
            c.val = x[WORD_W-1:0];
        end
        return c;
    endfunction

    function automatic logic [ADDR_W-1:0] entry_addr(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        return ADDR_W'(int'(row) * COLS + int'(col));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mwu_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Has no dependencies.
`default_nettype none

module mwu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/mwu_dp.sv =====
// Update datapath: one shared 32x32 multiplier plus the add, negate and clip steps
// of one weight update. Depends on mwu_pkg for widths, control struct and helpers.
`default_nettype none

module mwu_dp (
    input  logic                                i_clk,
    input  mwu_pkg::t_dp_ctrl                   i_ctrl,
    input  logic [mwu_pkg::WORD_W-1:0]          i_delta,
    input  logic [mwu_pkg::GAIN_W-1:0]          i_eta,
    input  logic [mwu_pkg::GAIN_W-1:0]          i_mu,
    input  logic [mwu_pkg::WORD_W-1:0]          i_act,
    input  logic [mwu_pkg::WORD_W-1:0]          i_weight,
    input  logic [mwu_pkg::WORD_W-1:0]          i_prev_step,
    output logic [mwu_pkg::WORD_W-1:0]          o_new_weight,
    output logic [mwu_pkg::WORD_W-1:0]          o_new_step,
    output logic                                o_sat
);

    logic [mwu_pkg::WORD_W-1:0]        r_dmag;
    logic                              r_dneg;
    logic [mwu_pkg::WORD_W-1:0]        r_amag;
    logic                              r_gneg;
    logic [mwu_pkg::WORD_W-1:0]        r_pmag;
    logic                              r_pneg;
    logic signed [mwu_pkg::WORD_W-1:0] r_weight;
    logic [mwu_pkg::PROD_W-1:0]        r_prod;
    logic [mwu_pkg::PART_W-1:0]        r_lo;
    logic [mwu_pkg::PART_W-1:0]        r_hi;
    logic [mwu_pkg::PART_W-1:0]        r_mom;
    logic [mwu_pkg::GMAG_W-1:0]        r_gmag;
    logic signed [mwu_pkg::SUM_W-1:0]  r_sum;
    logic signed [mwu_pkg::WORD_W-1:0] r_step;
    logic                              r_sat;
    logic [mwu_pkg::WORD_W-1:0]        r_wnew;

    logic [mwu_pkg::WORD_W-1:0]        mul_a;
    logic [mwu_pkg::WORD_W-1:0]        mul_b;
    logic [mwu_pkg::PROD_W-1:0]        mul_p;
    logic [mwu_pkg::FULL_W-1:0]        full_prod;
    logic signed [mwu_pkg::SUM_W-1:0]  grad_s;
    logic signed [mwu_pkg::SUM_W-1:0]  mom_s;
    logic signed [mwu_pkg::WORD_W:0]   w_sum;
    mwu_pkg::t_clip                    step_clip;
    mwu_pkg::t_clip                    weight_clip;

    always_comb begin
        if (i_ctrl.prod) begin
            mul_a = r_dmag;
            mul_b = r_amag;
        end else if (i_ctrl.lo) begin
            mul_a = r_prod[mwu_pkg::WORD_W-1:0];
            mul_b = mwu_pkg::WORD_W'(i_eta);
        end else if (i_ctrl.hi) begin
            mul_a = r_prod[mwu_pkg::PROD_W-1:mwu_pkg::WORD_W];
            mul_b = mwu_pkg::WORD_W'(i_eta);
        end else begin
            mul_a = r_pmag;
            mul_b = mwu_pkg::WORD_W'(i_mu);
        end
    end

    assign mul_p = mul_a * mul_b;

    assign full_prod = {r_hi, {mwu_pkg::WORD_W{1'b0}}} + mwu_pkg::FULL_W'(r_lo);

    always_comb begin
        grad_s = mwu_pkg::SUM_W'(r_gmag);
        if (r_gneg) begin
            grad_s = -grad_s;
        end
        mom_s = mwu_pkg::SUM_W'(r_mom[mwu_pkg::PART_W-1:mwu_pkg::GAIN_W]);
        if (r_pneg) begin
            mom_s = -mom_s;
        end
    end

    assign step_clip   = mwu_pkg::clip_word(r_sum);
    assign w_sum       = (mwu_pkg::WORD_W + 1)'(r_weight) + (mwu_pkg::WORD_W + 1)'(r_step);
    assign weight_clip = mwu_pkg::clip_word(mwu_pkg::SUM_W'(w_sum));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_delta) begin
            r_dmag <= mwu_pkg::mag32(i_delta);
            r_dneg <= i_delta[mwu_pkg::WORD_W-1];
        end
        if (i_ctrl.latch) begin
            r_amag   <= mwu_pkg::mag32(i_act);
            r_gneg   <= r_dneg ^ i_act[mwu_pkg::WORD_W-1];
            r_pmag   <= mwu_pkg::mag32(i_prev_step);
            r_pneg   <= i_prev_step[mwu_pkg::WORD_W-1];
            r_weight <= i_weight;
        end
        if (i_ctrl.prod) begin
            r_prod <= mul_p;
        end
        if (i_ctrl.lo) begin
            r_lo <= mul_p[mwu_pkg::PART_W-1:0];
        end
        if (i_ctrl.hi) begin
            r_hi <= mul_p[mwu_pkg::PART_W-1:0];
        end
        if (i_ctrl.mom) begin
            r_mom  <= mul_p[mwu_pkg::PART_W-1:0];
            r_gmag <= mwu_pkg::GMAG_W'(full_prod >> mwu_pkg::GRAD_SH);
        end
        if (i_ctrl.sum) begin
            r_sum <= grad_s + mom_s;
        end
        if (i_ctrl.clip) begin
            r_step <= step_clip.val;
            r_sat  <= step_clip.sat;
        end
        if (i_ctrl.wadd) begin
            r_wnew <= weight_clip.val;
            r_sat  <= r_sat | weight_clip.sat;
        end
    end

    assign o_new_weight = r_wnew;
    assign o_new_step   = r_step;
    assign o_sat        = r_sat;

endmodule

`default_nettype wire

// ===== rtl/momentum_weight_update.sv =====
// Top level of the momentum weight update block: sequencer, stores, ports.
// Depends on mwu_pkg, mwu_ram, mwu_dp and assert_macros.svh.
//
//   port group | direction | handshake               | payload
//   in         | sink      | i_in_valid / o_in_stall | operation, row, col, value
//   out        | source    | o_out_valid / i_out_stall | row, col, weight, saturated, last
//   cfg        | sink      | i_cfg_wr_en             | i_cfg_index, i_cfg_data
//
// A load word is written in the cycle it is accepted; a read word passes a read-request step and a result step.
// In an apply-delta word each row makes four passes through the shared 32x32 multiplier
// plus read, latch, sum, clip, weight-add and output steps.
// An output stall holds the sequencer at its result step until the word can be placed.
// Reset clears control state and loads the default gains; the stores hold nothing defined until written.
`default_nettype none

`include "assert_macros.svh"

module momentum_weight_update (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic [mwu_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [mwu_pkg::GAIN_W-1:0]             i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [1:0]                             i_operation,
    input  logic [mwu_pkg::FIELD_W-1:0]            i_row_index,
    input  logic [mwu_pkg::FIELD_W-1:0]            i_col_index,
    input  logic signed [mwu_pkg::WORD_W-1:0]      i_value,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [mwu_pkg::FIELD_W-1:0]            o_out_row,
    output logic [mwu_pkg::FIELD_W-1:0]            o_out_col,
    output logic signed [mwu_pkg::WORD_W-1:0]      o_weight_value,
    output logic                                   o_saturated,
    output logic                                   o_last
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_REQ,
        S_RD_OUT,
        S_ROW_RD,
        S_LATCH,
        S_PROD,
        S_LO,
        S_HI,
        S_MOM,
        S_SUM,
        S_CLIP,
        S_WADD,
        S_ROW_OUT
    } t_state;

    t_state                            r_state;
    logic [mwu_pkg::ROW_W-1:0]         r_sweep;
    logic [mwu_pkg::FIELD_W-1:0]       r_row_in;
    logic [mwu_pkg::FIELD_W-1:0]       r_col_in;
    logic                              r_rd_ok;
    logic [mwu_pkg::GAIN_W-1:0]        r_eta;
    logic [mwu_pkg::GAIN_W-1:0]        r_mu;
    logic                              r_out_valid;
    logic [mwu_pkg::FIELD_W-1:0]       r_out_row;
    logic [mwu_pkg::FIELD_W-1:0]       r_out_col;
    logic [mwu_pkg::WORD_W-1:0]        r_out_weight;
    logic                              r_out_sat;
    logic                              r_out_last;

    mwu_pkg::t_op                      op;
    mwu_pkg::t_dp_ctrl                 ctrl;
    logic                              in_acc;
    logic                              out_free;
    logic                              out_load;
    logic                              row_ok;
    logic                              col_ok;
    logic                              ld_weight;
    logic                              row_wb;
    logic [mwu_pkg::ADDR_W-1:0]        ld_addr;
    logic [mwu_pkg::ADDR_W-1:0]        sweep_addr;
    logic [mwu_pkg::ADDR_W-1:0]        read_addr;
    logic [mwu_pkg::ADDR_W-1:0]        st_wr_addr;
    logic [mwu_pkg::ADDR_W-1:0]        st_rd_addr;
    logic                              st_wr_en;
    logic [mwu_pkg::WORD_W-1:0]        w_wr_data;
    logic [mwu_pkg::WORD_W-1:0]        s_wr_data;
    logic [mwu_pkg::WORD_W-1:0]        w_rd_data;
    logic [mwu_pkg::WORD_W-1:0]        s_rd_data;
    logic [mwu_pkg::WORD_W-1:0]        a_rd_data;
    logic                              a_wr_en;
    logic [mwu_pkg::WORD_W-1:0]        dp_wnew;
    logic [mwu_pkg::WORD_W-1:0]        dp_step;
    logic                              dp_sat;

    assign op         = mwu_pkg::t_op'(i_operation);
    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign out_load   = ((r_state == S_RD_OUT) || (r_state == S_ROW_OUT)) && out_free;
    assign row_ok     = int'(i_row_index) < mwu_pkg::ROWS;
    assign col_ok     = int'(i_col_index) < mwu_pkg::COLS;

    assign ld_addr    = mwu_pkg::entry_addr((mwu_pkg::ROW_W)'(i_row_index),
                                            (mwu_pkg::COL_W)'(i_col_index));
    assign read_addr  = mwu_pkg::entry_addr((mwu_pkg::ROW_W)'(r_row_in),
                                            (mwu_pkg::COL_W)'(r_col_in));
    assign sweep_addr = mwu_pkg::entry_addr(r_sweep, (mwu_pkg::COL_W)'(r_col_in));

    assign ld_weight  = in_acc && (op == mwu_pkg::OP_LOAD_WEIGHT) && row_ok && col_ok;
    assign row_wb     = (r_state == S_ROW_OUT) && out_free;
    assign st_wr_en   = ld_weight || row_wb;
    assign st_wr_addr = row_wb ? sweep_addr : ld_addr;
    assign w_wr_data  = row_wb ? dp_wnew : i_value;
    assign s_wr_data  = row_wb ? dp_step : '0;
    assign st_rd_addr = ((r_state == S_RD_REQ) || (r_state == S_RD_OUT)) ? read_addr
                                                                           : sweep_addr;
    assign a_wr_en    = in_acc && (op == mwu_pkg::OP_LOAD_ACT) && row_ok;

    mwu_ram #(
        .WIDTH (mwu_pkg::WORD_W),
        .DEPTH (mwu_pkg::ROWS * mwu_pkg::COLS)
    ) u_weight_ram (
        .i_clk     (i_clk),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (st_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (st_rd_addr),
        .o_rd_data (w_rd_data)
    );

    mwu_ram #(
        .WIDTH (mwu_pkg::WORD_W),
        .DEPTH (mwu_pkg::ROWS * mwu_pkg::COLS)
    ) u_step_ram (
        .i_clk     (i_clk),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (st_wr_addr),
        .i_wr_data (s_wr_data),
        .i_rd_addr (st_rd_addr),
        .o_rd_data (s_rd_data)
    );

    mwu_ram #(
        .WIDTH (mwu_pkg::WORD_W),
        .DEPTH (mwu_pkg::ROWS)
    ) u_act_ram (
        .i_clk     (i_clk),
        .i_wr_en   (a_wr_en),
        .i_wr_addr ((mwu_pkg::ROW_W)'(i_row_index)),
        .i_wr_data (i_value),
        .i_rd_addr (r_sweep),
        .o_rd_data (a_rd_data)
    );

    always_comb begin
        ctrl          = '0;
        ctrl.ld_delta = in_acc && (op == mwu_pkg::OP_APPLY_DELTA);
        ctrl.latch    = (r_state == S_LATCH);
        ctrl.prod     = (r_state == S_PROD);
        ctrl.lo       = (r_state == S_LO);
        ctrl.hi       = (r_state == S_HI);
        ctrl.mom      = (r_state == S_MOM);
        ctrl.sum      = (r_state == S_SUM);
        ctrl.clip     = (r_state == S_CLIP);
        ctrl.wadd     = (r_state == S_WADD);
    end

    mwu_dp u_dp (
        .i_clk        (i_clk),
        .i_ctrl       (ctrl),
        .i_delta      (i_value),
        .i_eta        (r_eta),
        .i_mu         (r_mu),
        .i_act        (a_rd_data),
        .i_weight     (w_rd_data),
        .i_prev_step  (s_rd_data),
        .o_new_weight (dp_wnew),
        .o_new_step   (dp_step),
        .o_sat        (dp_sat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sweep     <= '0;
            r_rd_ok     <= 1'b0;
            r_eta       <= mwu_pkg::ETA_RESET;
            r_mu        <= mwu_pkg::MU_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == mwu_pkg::CFG_LEARNING_RATE) begin
                    r_eta <= i_cfg_data;
                end else begin
                    r_mu <= i_cfg_data;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_row_in <= i_row_index;
                        r_col_in <= i_col_index;
                        r_rd_ok  <= row_ok && col_ok;
                        case (op)
                            mwu_pkg::OP_READ_WEIGHT: begin
                                r_state <= S_RD_REQ;
                            end
                            mwu_pkg::OP_APPLY_DELTA: begin
                                if (col_ok) begin
                                    r_sweep <= '0;
                                    r_state <= S_ROW_RD;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_RD_REQ: begin
                    r_state <= S_RD_OUT;
                end
                S_RD_OUT: begin
                    if (out_free) begin
                        r_out_row    <= r_row_in;
                        r_out_col    <= r_col_in;
                        r_out_weight <= r_rd_ok ? w_rd_data : '0;
                        r_out_sat    <= 1'b0;
                        r_out_last   <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                S_ROW_RD: r_state <= S_LATCH;
                S_LATCH:  r_state <= S_PROD;
                S_PROD:   r_state <= S_LO;
                S_LO:     r_state <= S_HI;
                S_HI:     r_state <= S_MOM;
                S_MOM:    r_state <= S_SUM;
                S_SUM:    r_state <= S_CLIP;
                S_CLIP:   r_state <= S_WADD;
                S_WADD:   r_state <= S_ROW_OUT;
                S_ROW_OUT: begin
                    if (out_free) begin
                        r_out_row    <= (mwu_pkg::FIELD_W)'(r_sweep);
                        r_out_col    <= r_col_in;
                        r_out_weight <= dp_wnew;
                        r_out_sat    <= dp_sat;
                        r_out_last   <= (r_sweep == mwu_pkg::LAST_ROW);
                        if (r_sweep == mwu_pkg::LAST_ROW) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_sweep <= r_sweep + 1'b1;
                            r_state <= S_ROW_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_row      = r_out_row;
    assign o_out_col      = r_out_col;
    assign o_weight_value = r_out_weight;
    assign o_saturated    = r_out_sat;
    assign o_last         = r_out_last;

    `MWU_ASSERT_NEXT(a_sweep_starts_at_row0,
        in_acc && (op == mwu_pkg::OP_APPLY_DELTA) && col_ok,
        (r_state == S_ROW_RD) && (r_sweep == '0),
        "Delta sweep did not start at the first row.")

    `MWU_ASSERT_IMPLY(a_partial_column_busy,
        o_out_valid && !o_last,
        r_state != S_IDLE,
        "A non-final column word is pending while the sequencer is idle.")

    `MWU_ASSERT_IMPLY(a_word_from_result_step,
        $rose(o_out_valid),
        ($past(r_state) == S_RD_OUT) || ($past(r_state) == S_ROW_OUT),
        "An output word appeared outside a result step.")

endmodule

`default_nettype wire
